// ===== sv/sle_pkg.sv =====
// sle_pkg: shared types and constants of the sorted list engine
// request and status codes, controller/datapath command and status words
// no dependencies
`timescale 1ns / 1ps

package sle_pkg;

    // default sizing
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // request kinds
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_POP    = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } stat_code_t;

    // ram read address source
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_CNT_M1,
        RD_IDX_M2,
        RD_IDX_P1,
        RD_IDX_P2
    } rd_sel_t;

    // ram write source
    typedef enum logic [1:0] {
        WR_IDX_RDATA,
        WR_IDX_VAL,
        WR_ZERO_VAL
    } wr_sel_t;

    // index register update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    // count register update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } cnt_op_t;

    // controller to datapath
    typedef struct packed {
        logic      load_req;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      wr_en;
        wr_sel_t   wr_sel;
        idx_op_t   idx_op;
        cnt_op_t   cnt_op;
        logic      set_full;
        logic      set_miss;
        logic      capture_pop;
        logic      load_out;
    } sle_cmd_t;

    // datapath to controller
    typedef struct packed {
        req_kind_t req;
        logic      full;
        logic      empty;
        logic      key_ge;
        logic      val_eq;
        logic      idx_one;
        logic      idx_last;
        logic      idx_near_last;
        logic      out_free;
    } sle_stat_t;

endpackage

// ===== sv/sle_ram.sv =====
// sle_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sle_ctrl.sv =====
// sle_ctrl: sequencing state machine of the sorted list engine
// depends on sle_pkg
`timescale 1ns / 1ps

module sle_ctrl
    import sle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sle_stat_t stat,
    output sle_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DECODE    = 8'b0000_0010,
        S_INS_CMP   = 8'b0000_0100,
        S_INS_LAST  = 8'b0000_1000,
        S_REM_CMP   = 8'b0001_0000,
        S_SHIFT     = 8'b0010_0000,
        S_HEAD      = 8'b0100_0000,
        S_HEAD_WAIT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = RD_ZERO;
        cmd.wr_sel      = WR_IDX_RDATA;
        cmd.idx_op      = IDX_HOLD;
        cmd.cnt_op      = CNT_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.req)
                    REQ_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = S_HEAD;
                        end
                        else if (stat.empty)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_ZERO_VAL;
                            cmd.cnt_op = CNT_INC;
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_COUNT;
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_CNT_M1;
                            state_next = S_INS_CMP;
                        end
                    end
                    REQ_REMOVE, REQ_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_miss = 1'b1;
                            state_next   = S_HEAD;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_ZERO;
                            state_next = S_REM_CMP;
                        end
                    end
                    default:
                    begin
                        cmd.cnt_op = CNT_CLEAR;
                        state_next = S_HEAD;
                    end
                endcase
            end
            // walk down from the top, moving larger-or-equal entries up one
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.key_ge)
                begin
                    cmd.wr_sel = WR_IDX_RDATA;
                    cmd.idx_op = IDX_DEC;
                    if (stat.idx_one)
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_IDX_M2;
                    end
                end
                else
                begin
                    cmd.wr_sel = WR_IDX_VAL;
                    cmd.cnt_op = CNT_INC;
                    state_next = S_HEAD;
                end
            end
            // new value becomes the head
            S_INS_LAST:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_ZERO_VAL;
                cmd.cnt_op = CNT_INC;
                state_next = S_HEAD;
            end
            // search upward, pop matches at the head at once
            S_REM_CMP:
            begin
                if (stat.val_eq || stat.req == REQ_POP)
                begin
                    cmd.capture_pop = (stat.req == REQ_POP);
                    if (stat.idx_last)
                    begin
                        cmd.cnt_op = CNT_DEC;
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_IDX_P1;
                        state_next = S_SHIFT;
                    end
                end
                else if (stat.idx_last)
                begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_HEAD;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                end
            end
            // close the gap, one entry per cycle
            S_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_IDX_RDATA;
                cmd.idx_op = IDX_INC;
                if (stat.idx_near_last)
                begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_HEAD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P2;
                end
            end
            S_HEAD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ZERO;
                state_next = S_HEAD_WAIT;
            end
            // hand the result to the output register once it is free
            S_HEAD_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sle_dpath.sv =====
// sle_dpath: sorted store ram, index and count registers, result register
// depends on sle_pkg and sle_ram
`timescale 1ns / 1ps

module sle_dpath
    import sle_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          req_type,
    input  logic signed [DATA_WIDTH-1:0]        item_value,
    input  sle_cmd_t                            cmd,
    output sle_stat_t                           stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [$clog2(CAPACITY+1)-1:0]       entry_count,
    output logic signed [DATA_WIDTH-1:0]        smallest_value,
    output logic signed [DATA_WIDTH-1:0]        popped_value
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    req_kind_t               type_reg;
    logic [DATA_WIDTH-1:0]   val_reg;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [DATA_WIDTH-1:0]   popped_reg;
    stat_code_t              stat_reg;

    logic                    out_valid_reg;
    stat_code_t              out_status_reg;
    logic [CW-1:0]           out_count_reg;
    logic [DATA_WIDTH-1:0]   out_small_reg;
    logic [DATA_WIDTH-1:0]   out_popped_reg;

    logic [CW-1:0]           idx_m1, idx_m2, idx_p1, idx_p2, count_m1;
    logic [CW-1:0]           rd_full, wr_full;
    logic [DATA_WIDTH-1:0]   wr_data;
    logic [DATA_WIDTH-1:0]   rdata;
    logic                    out_free;

    // neighbor indexes
    assign idx_m1   = idx_reg - CW'(1);
    assign idx_m2   = idx_reg - CW'(2);
    assign idx_p1   = idx_reg + CW'(1);
    assign idx_p2   = idx_reg + CW'(2);
    assign count_m1 = count_reg - CW'(1);

    // read address select
    always_comb
    begin
        case (cmd.rd_sel)
            RD_CNT_M1: rd_full = count_m1;
            RD_IDX_M2: rd_full = idx_m2;
            RD_IDX_P1: rd_full = idx_p1;
            RD_IDX_P2: rd_full = idx_p2;
            default:   rd_full = '0;
        endcase
    end

    // write address and data select
    always_comb
    begin
        case (cmd.wr_sel)
            WR_IDX_VAL:
            begin
                wr_full = idx_reg;
                wr_data = val_reg;
            end
            WR_ZERO_VAL:
            begin
                wr_full = '0;
                wr_data = val_reg;
            end
            default:
            begin
                wr_full = idx_reg;
                wr_data = rdata;
            end
        endcase
    end

    sle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_full[AW-1:0]),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_full[AW-1:0]),
        .rdata (rdata)
    );

    // index and count updates
    always_comb
    begin
        case (cmd.idx_op)
            IDX_ZERO:  idx_next = '0;
            IDX_COUNT: idx_next = count_reg;
            IDX_INC:   idx_next = idx_p1;
            IDX_DEC:   idx_next = idx_m1;
            default:   idx_next = idx_reg;
        endcase
        case (cmd.cnt_op)
            CNT_INC:   count_next = count_reg + CW'(1);
            CNT_DEC:   count_next = count_m1;
            CNT_CLEAR: count_next = '0;
            default:   count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            type_reg   <= req_kind_t'(req_type);
            val_reg    <= item_value;
            popped_reg <= '0;
            stat_reg   <= ST_DONE;
        end
        else
        begin
            if (cmd.set_full)
            begin
                stat_reg <= ST_FULL;
            end
            if (cmd.set_miss)
            begin
                stat_reg <= ST_MISS;
            end
            if (cmd.capture_pop)
            begin
                popped_reg <= rdata;
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= stat_reg;
            out_count_reg  <= count_reg;
            out_small_reg  <= (count_reg == '0) ? '0 : rdata;
            out_popped_reg <= popped_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // status to controller
    always_comb
    begin
        stat.req           = type_reg;
        stat.full          = (count_reg == CW'(CAPACITY));
        stat.empty         = (count_reg == '0);
        stat.key_ge        = ($signed(rdata) >= $signed(val_reg));
        stat.val_eq        = (rdata == val_reg);
        stat.idx_one       = (idx_reg == CW'(1));
        stat.idx_last      = (idx_reg == count_m1);
        stat.idx_near_last = (idx_p2 == count_reg);
        stat.out_free      = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign entry_count    = out_count_reg;
    assign smallest_value = out_small_reg;
    assign popped_value   = out_popped_reg;

    // count stays within the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // every ram write lands inside the store
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (wr_full < CW'(CAPACITY)))
        else $error("store write out of range");

    // a pending result is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result register overrun");

    // a dropped insert is reported only with a full store
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && stat_reg == ST_FULL) |-> (count_reg == CW'(CAPACITY)))
        else $error("full status with room left");

endmodule

// ===== sv/sorted_list_engine_unit.sv =====
// sorted_list_engine_unit: top level of the sorted list engine
// depends on sle_pkg, sle_ctrl, sle_dpath, sle_ram
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_ready    req_type, item_value
//   out      output     out_valid/out_ready  status, entry_count, smallest_value,
//                                            popped_value
//
// one request is in flight at a time; the time that a request takes grows with
// the number of entries (least for a clear or failed insert, most for an insert
// of a new smallest value), set by the single ram read and write per cycle used
// to search and shift entries.
// reset empties the store at once; stored values are not cleared.
// a stalled result waits in the output register while the next word is taken.
`timescale 1ns / 1ps

module sorted_list_engine_unit
    import sle_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic signed [DATA_WIDTH-1:0]  item_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [$clog2(CAPACITY+1)-1:0] entry_count,
    output logic signed [DATA_WIDTH-1:0]  smallest_value,
    output logic signed [DATA_WIDTH-1:0]  popped_value
);

    sle_cmd_t  cmd;
    sle_stat_t stat;

    // sequencing
    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store and result registers
    sle_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_type       (req_type),
        .item_value     (item_value),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .entry_count    (entry_count),
        .smallest_value (smallest_value),
        .popped_value   (popped_value)
    );

endmodule

// ===== test/sorted_list_engine_unit_tb.sv =====
// sorted_list_engine_unit_tb: self-checking testbench of the sorted list engine
// drives directed then random requests, predicts each result with a queue-based
// shadow list and checks every output word; depends on sle_pkg and the rtl
`timescale 1ns / 1ps

module sorted_list_engine_unit_tb;
    import sle_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int DW  = DATA_WIDTH_DEF;
    localparam int CW  = $clog2(CAP + 1);

    localparam logic signed [DW-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [DW-1:0] VAL_MIN = 32'sh80000000;

    // one expected output word
    typedef struct {
        stat_code_t            st;
        logic [CW-1:0]         cnt;
        logic signed [DW-1:0]  low;
        logic signed [DW-1:0]  popped;
    } list_result_t;

    // one row of the directed table; fixed marks a typed-in expectation
    typedef struct {
        req_kind_t             kind;
        logic signed [DW-1:0]  val;
        bit                    fixed;
        list_result_t          want;
    } list_row_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [1:0]            req_type   = 2'd0;
    logic signed [DW-1:0]  item_value = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [1:0]            status;
    logic [CW-1:0]         entry_count;
    logic signed [DW-1:0]  smallest_value;
    logic signed [DW-1:0]  popped_value;

    logic signed [DW-1:0]  shadow_list[$];
    list_result_t          pending_results[$];
    int                    fail_count    = 0;
    bit                    calm          = 1'b0;
    int                    hold_requests = 0;

    // directed requests: empty store, extremes, head removal, absent value, fill to full
    list_row_t dir_rows [0:25] = '{
        '{REQ_POP,    32'sd0,       1'b1, '{ST_MISS, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_REMOVE, 32'sd7,       1'b1, '{ST_MISS, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, VAL_MAX,      1'b1, '{ST_DONE, 5'd1,  VAL_MAX, 32'sd0}},
        '{REQ_INSERT, VAL_MIN,      1'b1, '{ST_DONE, 5'd2,  VAL_MIN, 32'sd0}},
        '{REQ_REMOVE, VAL_MIN,      1'b1, '{ST_DONE, 5'd1,  VAL_MAX, 32'sd0}},
        '{REQ_REMOVE, 32'sd3,       1'b1, '{ST_MISS, 5'd1,  VAL_MAX, 32'sd0}},
        '{REQ_POP,    -32'sd1,      1'b1, '{ST_DONE, 5'd0,  32'sd0,  VAL_MAX}},
        '{REQ_CLEAR,  VAL_MIN,      1'b1, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sd5,       1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, VAL_MAX,      1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sd0,       1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, -32'sd1,      1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sh55555555, 1'b0, '{ST_DONE, 5'd0, 32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'shaaaaaaaa, 1'b0, '{ST_DONE, 5'd0, 32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sd5,       1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, -32'sd5,      1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sd100,     1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, VAL_MIN,      1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, -32'sd100,    1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sh7ffffffe, 1'b0, '{ST_DONE, 5'd0, 32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sh80000001, 1'b0, '{ST_DONE, 5'd0, 32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sd42,      1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sh12345678, 1'b0, '{ST_DONE, 5'd0, 32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sd1,       1'b0, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}},
        '{REQ_INSERT, 32'sd9,       1'b1, '{ST_FULL, 5'd16, VAL_MIN, 32'sd0}},
        '{REQ_CLEAR,  32'sd0,       1'b1, '{ST_DONE, 5'd0,  32'sd0,  32'sd0}}
    };

    sorted_list_engine_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .item_value     (item_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .entry_count    (entry_count),
        .smallest_value (smallest_value),
        .popped_value   (popped_value)
    );

    // clock
    always #10 clk = ~clk;

    // apply one request to the shadow list and return the word it should produce
    function automatic list_result_t predict_list_result(req_kind_t kind,
                                                         logic signed [DW-1:0] val);
        list_result_t r;
        int pos;
        r.st     = ST_DONE;
        r.popped = '0;
        pos      = 0;
        case (kind)
            REQ_INSERT:
            begin
                if (shadow_list.size() >= CAP)
                    r.st = ST_FULL;
                else
                begin
                    // ahead of equal values
                    while (pos < shadow_list.size() && shadow_list[pos] < val)
                        pos++;
                    shadow_list.insert(pos, val);
                end
            end
            REQ_REMOVE:
            begin
                while (pos < shadow_list.size() && shadow_list[pos] != val)
                    pos++;
                if (pos < shadow_list.size())
                    shadow_list.delete(pos);
                else
                    r.st = ST_MISS;
            end
            REQ_POP:
            begin
                if (shadow_list.size() == 0)
                    r.st = ST_MISS;
                else
                    r.popped = shadow_list.pop_front();
            end
            default:
                shadow_list.delete();
        endcase
        r.cnt = CW'(shadow_list.size());
        r.low = (shadow_list.size() > 0) ? shadow_list[0] : '0;
        return r;
    endfunction

    // offer one word and wait for it to be taken; the expectation is queued on acceptance
    task automatic offer_word(req_kind_t kind, logic signed [DW-1:0] val, bit fixed,
                              list_result_t typed_want);
        int gap;
        list_result_t predicted;
        gap = 0;
        if (!calm && $urandom_range(99) < 14)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        item_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_list_result(kind, val);
        pending_results.push_back(fixed ? typed_want : predicted);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // value for a random request: mostly stored values for removes, else mixed
    function automatic logic signed [DW-1:0] pick_value(req_kind_t kind);
        logic signed [DW-1:0] v;
        if (kind == REQ_REMOVE && shadow_list.size() > 0 && $urandom_range(99) < 70)
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       v = VAL_MAX;
                    1:       v = VAL_MIN;
                    2:       v = '0;
                    default: v = -1;
                endcase
            end
            1, 2, 3:
            begin
                // narrow range so duplicates show up
                v = $urandom_range(15);
                v = v - 8;
            end
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    // request kind by phase: 0 fill-heavy, 1 drain-heavy, 2 mixed
    function automatic req_kind_t pick_kind(int mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            0:
            begin
                if (r < 70)      return REQ_INSERT;
                else if (r < 85) return REQ_REMOVE;
                else if (r < 99) return REQ_POP;
                else             return REQ_CLEAR;
            end
            1:
            begin
                if (r < 25)      return REQ_INSERT;
                else if (r < 60) return REQ_REMOVE;
                else if (r < 98) return REQ_POP;
                else             return REQ_CLEAR;
            end
            default:
            begin
                if (r < 45)      return REQ_INSERT;
                else if (r < 70) return REQ_REMOVE;
                else if (r < 95) return REQ_POP;
                else             return REQ_CLEAR;
            end
        endcase
    endfunction

    task automatic note_failure(string what, list_result_t want);
        fail_count++;
        if (fail_count <= 10)
            $display("%t %s: exp st=%0d cnt=%0d low=%0d pop=%0d got st=%0d cnt=%0d low=%0d pop=%0d",
                     $realtime, what, want.st, want.cnt, want.low, want.popped,
                     status, entry_count, smallest_value, popped_value);
    endtask

    // stimulus
    initial
    begin : stimulus
        int k;
        int blk;
        req_kind_t kind;
        list_result_t none;
        none.st     = ST_DONE;
        none.cnt    = '0;
        none.low    = '0;
        none.popped = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (k = 0; k < 26; k++)
            offer_word(dir_rows[k].kind, dir_rows[k].val, dir_rows[k].fixed, dir_rows[k].want);

        // random phases
        for (blk = 0; blk < 12; blk++)
        begin
            calm = (blk == 3);
            // long output stall while words keep coming
            if (blk == 5)
                hold_requests++;
            // sender pause until the pipe is empty
            if (blk == 8)
            begin
                in_valid <= 1'b0;
                wait_results_drained();
            end
            repeat (128)
            begin
                kind = pick_kind(blk % 3);
                offer_word(kind, pick_value(kind), 1'b0, none);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        wait_results_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("sorted_list_engine_unit test passed");
        else
            $display("sorted_list_engine_unit test failed");
        $finish;
    end

    // output side ready: random stalls plus one long hold-off on request
    initial
    begin : sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(99) < 14)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                want.st     = ST_DONE;
                want.cnt    = '0;
                want.low    = '0;
                want.popped = '0;
                note_failure("unexpected word", want);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st || entry_count !== want.cnt
                    || smallest_value !== want.low || popped_value !== want.popped)
                    note_failure("mismatch", want);
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        #10_000_000;
        $display("sorted_list_engine_unit test failed");
        $finish;
    end

endmodule
